### rtl/core/bfs_pkg.sv
package bfs_pkg;

    localparam int unsigned FIELD_W = 4;
    localparam int unsigned PAR_W   = 5;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_CLEAR  = 2'd1,
        MODE_SEARCH = 2'd2,
        MODE_PATH   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_NOPTH = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SRCH_INIT,
        S_POP,
        S_POP_WAIT,
        S_EDGE_REQ,
        S_EDGE_WAIT,
        S_EMIT_PAR,
        S_WALK,
        S_WALK_CHK,
        S_EMIT_PATH,
        S_EMIT_ONE
    } fsm_t;

    localparam logic [PAR_W-1:0] PAR_NONE = '1;

endpackage

### rtl/core/bfs_parent_tree_path.sv
// channel | signals                           | direction
// input   | valid, stall, mode, from_node, to_node | in
// output  | out_valid, out_stall, status, node_id, parent_node, last | out
// after a transfer stall stays high through S_ADD and S_EMIT_ONE for add edge and through S_EMIT_ONE for clear graph
// a search holds it through queue pops and edge reads, one edge read at a time, then a parent emit per node
// a path query holds it while walking parents from to_node, then emits the path, or one result when no path is found
// reset clears counts, visited marks and parents at once (flip-flops), no clearing pass
// stall on the output holds the result and lengthens each emit step; input stall is high whenever busy
module bfs_parent_tree_path #(
    parameter int unsigned NODE_COUNT = 16,
    parameter int unsigned MAX_DEGREE = 8
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           valid,
    output logic                           stall,
    input  logic [1:0]                     mode,
    input  logic [bfs_pkg::FIELD_W-1:0]    from_node,
    input  logic [bfs_pkg::FIELD_W-1:0]    to_node,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [1:0]                     status,
    output logic [bfs_pkg::FIELD_W-1:0]    node_id,
    output logic signed [bfs_pkg::PAR_W-1:0] parent_node,
    output logic                           last
);

    import bfs_pkg::*;

    localparam int unsigned NW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int unsigned DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
    localparam int unsigned CW = $clog2(MAX_DEGREE + 1);
    localparam int unsigned QW = $clog2(NODE_COUNT + 1);
    localparam int unsigned EW = NW + DW;

    fsm_t state_reg, state_next;

    logic [CW-1:0]    cnt_reg [NODE_COUNT];
    logic [NODE_COUNT-1:0] seen_reg;
    logic [PAR_W-1:0] par_reg [NODE_COUNT];
    logic [FIELD_W-1:0] src_reg;

    logic [1:0]         mode_reg;
    logic [FIELD_W-1:0] a_reg, b_reg;
    logic [QW-1:0]      head_reg, tail_reg;
    logic [NW-1:0]      node_reg;
    logic [CW-1:0]      e_reg;
    logic [QW-1:0]      len_reg;
    logic [QW-1:0]      idx_reg;
    logic [PAR_W-1:0]   cur_reg;
    logic [NW-1:0]      last_node_reg;
    logic               full_reg;

    logic               ov_reg;
    logic [1:0]         st_reg;
    logic [FIELD_W-1:0] nid_reg;
    logic [PAR_W-1:0]   pn_reg;
    logic               last_reg;

    logic               e_we, q_we, p_we;
    logic [EW-1:0]      e_waddr, e_raddr;
    logic [NW-1:0]      e_wdata, e_rdata;
    logic [NW-1:0]      q_waddr, q_raddr, q_wdata, q_rdata;
    logic [NW-1:0]      p_waddr, p_raddr, p_wdata, p_rdata;

    bfs_ram #(.WIDTH(NW), .DEPTH(NODE_COUNT * (1 << DW))) u_edge (
        .clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
        .raddr(e_raddr), .rdata(e_rdata));
    bfs_ram #(.WIDTH(NW), .DEPTH(1 << NW)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));
    bfs_ram #(.WIDTH(NW), .DEPTH(1 << NW)) u_stack (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));

    logic out_free;
    logic out_load;
    logic a_ok, b_ok;
    logic [NW-1:0] a_i, b_i, nb_i, cur_i;
    logic nb_ok, cur_ok;
    logic path_ok;

    assign out_free = !ov_reg || !out_stall;
    assign out_load = out_free && ((state_reg == S_EMIT_PAR) || (state_reg == S_EMIT_ONE)
                      || (state_reg == S_EMIT_PATH && idx_reg != '0));
    assign a_ok  = {{(32-FIELD_W){1'b0}}, a_reg} < NODE_COUNT;
    assign b_ok  = {{(32-FIELD_W){1'b0}}, b_reg} < NODE_COUNT;
    assign a_i   = a_reg[NW-1:0];
    assign b_i   = b_reg[NW-1:0];
    assign nb_i  = e_rdata;
    assign nb_ok = {{(32-NW){1'b0}}, e_rdata} < NODE_COUNT;
    assign cur_i = cur_reg[NW-1:0];
    assign cur_ok = !cur_reg[PAR_W-1] || (NODE_COUNT > 16);
    assign path_ok = (cur_reg == PAR_NONE) && (len_reg != '0) && b_ok
                     && (FIELD_W'(last_node_reg) == src_reg);

    assign stall       = (state_reg != S_IDLE);
    assign out_valid   = ov_reg;
    assign status      = st_reg;
    assign node_id     = nid_reg;
    assign parent_node = pn_reg;
    assign last        = last_reg;

    assign e_we    = (state_reg == S_ADD) && a_ok && b_ok && (cnt_reg[a_i] < MAX_DEGREE);
    assign e_waddr = {a_i, cnt_reg[a_i][DW-1:0]};
    assign e_wdata = b_i;
    assign e_raddr = {node_reg, e_reg[DW-1:0]};

    always_comb
    begin
        q_we    = 1'b0;
        q_waddr = tail_reg[NW-1:0];
        q_wdata = a_i;
        q_raddr = head_reg[NW-1:0];
        p_we    = 1'b0;
        p_waddr = len_reg[NW-1:0];
        p_wdata = cur_i;
        p_raddr = len_reg[NW-1:0] - NW'(idx_reg) - NW'(out_free);
        if (state_reg == S_SRCH_INIT && a_ok)
        begin
            q_we    = 1'b1;
            q_waddr = '0;
        end
        if (state_reg == S_EDGE_WAIT && nb_ok && !seen_reg[nb_i] && tail_reg < NODE_COUNT)
        begin
            q_we    = 1'b1;
            q_wdata = nb_i;
        end
        if (state_reg == S_WALK && cur_ok && len_reg < NODE_COUNT)
        begin
            p_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (valid)
                begin
                    unique case (mode_t'(mode))
                        MODE_ADD:    state_next = S_ADD;
                        MODE_CLEAR:  state_next = S_EMIT_ONE;
                        MODE_SEARCH: state_next = S_SRCH_INIT;
                        MODE_PATH:   state_next = S_WALK;
                    endcase
                end
            end
            S_ADD:       state_next = S_EMIT_ONE;
            S_SRCH_INIT: state_next = S_POP;
            S_POP:
            begin
                if (head_reg < tail_reg && head_reg < NODE_COUNT)
                    state_next = S_POP_WAIT;
                else
                    state_next = S_EMIT_PAR;
            end
            S_POP_WAIT:  state_next = S_EDGE_REQ;
            S_EDGE_REQ:
            begin
                if (e_reg < cnt_reg[node_reg])
                    state_next = S_EDGE_WAIT;
                else
                    state_next = S_POP;
            end
            S_EDGE_WAIT: state_next = S_EDGE_REQ;
            S_EMIT_PAR:
            begin
                if (out_free && idx_reg == QW'(NODE_COUNT - 1))
                    state_next = S_IDLE;
            end
            S_WALK:
            begin
                if (!b_ok || !cur_ok || len_reg >= NODE_COUNT)
                    state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                if (path_ok)
                    state_next = S_EMIT_PATH;
                else
                    state_next = S_EMIT_ONE;
            end
            S_EMIT_PATH:
            begin
                if (out_free && idx_reg == len_reg)
                    state_next = S_IDLE;
            end
            S_EMIT_ONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:     state_next = S_IDLE;
        endcase
    end

    logic [NW-1:0] pop_node;
    assign pop_node = q_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            seen_reg  <= '0;
            src_reg   <= '0;
            ov_reg    <= 1'b0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                cnt_reg[i] <= '0;
                par_reg[i] <= PAR_NONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= out_load || (ov_reg && out_stall);
            unique case (state_reg)
                S_IDLE:
                begin
                    mode_reg <= mode;
                    a_reg    <= from_node;
                    b_reg    <= to_node;
                    idx_reg  <= '0;
                    len_reg  <= '0;
                    cur_reg  <= {1'b0, to_node};
                    if (valid && mode_t'(mode) == MODE_CLEAR)
                    begin
                        for (int i = 0; i < NODE_COUNT; i++)
                            cnt_reg[i] <= '0;
                    end
                end
                S_ADD:
                begin
                    full_reg <= !e_we;
                    if (e_we)
                    begin
                        cnt_reg[a_i] <= cnt_reg[a_i] + 1'b1;
                    end
                end
                S_SRCH_INIT:
                begin
                    src_reg  <= a_reg;
                    head_reg <= '0;
                    for (int i = 0; i < NODE_COUNT; i++)
                        par_reg[i] <= PAR_NONE;
                    if (a_ok)
                    begin
                        seen_reg <= {{(NODE_COUNT-1){1'b0}}, 1'b1} << a_i;
                        tail_reg <= QW'(1);
                    end
                    else
                    begin
                        seen_reg <= '0;
                        tail_reg <= '0;
                    end
                end
                S_POP:
                begin
                    e_reg <= '0;
                    if (head_reg < tail_reg)
                        head_reg <= head_reg + 1'b1;
                end
                S_POP_WAIT:
                begin
                    node_reg <= pop_node;
                end
                S_EDGE_REQ: ;
                S_EDGE_WAIT:
                begin
                    e_reg <= e_reg + 1'b1;
                    if (q_we)
                    begin
                        seen_reg[nb_i] <= 1'b1;
                        par_reg[nb_i]  <= PAR_W'(node_reg);
                        tail_reg       <= tail_reg + 1'b1;
                    end
                end
                S_EMIT_PAR:
                begin
                    if (out_free)
                    begin
                        st_reg   <= ST_OK;
                        nid_reg  <= FIELD_W'(idx_reg);
                        pn_reg   <= par_reg[idx_reg[NW-1:0]];
                        last_reg <= (idx_reg == QW'(NODE_COUNT - 1));
                        idx_reg  <= idx_reg + 1'b1;
                    end
                end
                S_WALK:
                begin
                    if (b_ok && cur_ok && len_reg < NODE_COUNT)
                    begin
                        len_reg       <= len_reg + 1'b1;
                        last_node_reg <= cur_i;
                        cur_reg       <= par_reg[cur_i];
                    end
                end
                S_WALK_CHK:
                begin
                    if (!path_ok)
                        len_reg <= '0;
                    idx_reg <= '0;
                end
                S_EMIT_PATH:
                begin
                    if (out_free && idx_reg != len_reg)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    if (out_free && idx_reg != '0)
                    begin
                        st_reg   <= ST_OK;
                        nid_reg  <= FIELD_W'(p_rdata);
                        pn_reg   <= par_reg[p_rdata];
                        last_reg <= (idx_reg == len_reg);
                    end
                end
                S_EMIT_ONE:
                begin
                    if (out_free)
                    begin
                        last_reg <= 1'b1;
                        if (mode_t'(mode_reg) == MODE_ADD)
                        begin
                            st_reg  <= full_reg ? ST_FULL : ST_OK;
                            nid_reg <= a_reg;
                            pn_reg  <= '0;
                        end
                        else if (mode_t'(mode_reg) == MODE_CLEAR)
                        begin
                            st_reg  <= ST_OK;
                            nid_reg <= '0;
                            pn_reg  <= '0;
                        end
                        else
                        begin
                            st_reg  <= ST_NOPTH;
                            nid_reg <= b_reg;
                            pn_reg  <= PAR_NONE;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> stall)
        else $error("accepted while busy");
    a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |-> (head_reg <= tail_reg))
        else $error("queue head passed tail");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && out_stall) |=> (ov_reg && $stable(nid_reg)))
        else $error("stalled transfer changed");
`endif

endmodule

### rtl/core/bfs_ram.sv
module bfs_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
